FILE: sv/escape_sequence_line_decoder_macros.svh
// ----------------------------------------------------------------------------
// Escape sequence line decoder: assertion macros
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_LINE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_LINE_DECODER_MACROS_SVH

// Same-cycle implication.
`define ESLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escape decoder check failed");

// Next-cycle implication.
`define ESLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape decoder check failed");

`endif

FILE: sv/esld_pkg.sv
// ----------------------------------------------------------------------------
// Escape sequence line decoder: shared package
// Run record passed from the classifier to the output sequencer, and queue
// sizing.
// ----------------------------------------------------------------------------
package esld_pkg;

  localparam int unsigned RUN_MAX     = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [7:0] byte_t;

  // Decoded bytes of one request, the count of them and the line end flag
  typedef struct packed {
    byte_t [RUN_MAX-1:0] data;
    logic  [1:0]         cnt;
    logic                eol;
  } run_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

FILE: sv/esld_front.sv
// ----------------------------------------------------------------------------
// Escape sequence line decoder: front end
// Accepts raw bytes, tracks the escape mode and builds the run of decoded
// bytes that each request causes.
// ----------------------------------------------------------------------------
module esld_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] in_byte
  input  logic             s_tlast,   // end_of_line
  input  esld_pkg::q_stat_t q_stat,
  output logic             push,
  output esld_pkg::run_t   push_run
);
  import esld_pkg::*;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_BSL   = 2'd1;
  localparam logic [1:0] MODE_PCT   = 2'd2;
  localparam logic [1:0] MODE_HEX1  = 2'd3;

  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_PCT   = 8'h25;
  localparam byte_t CH_LOW_R = 8'h72;
  localparam byte_t CH_LOW_N = 8'h6E;
  localparam byte_t CH_LOW_T = 8'h74;
  localparam byte_t CH_UP_T  = 8'h54;
  localparam byte_t CH_LOW_S = 8'h73;
  localparam byte_t CH_UP_S  = 8'h53;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t MARK_TAB = 8'h02;
  localparam byte_t MARK_SP  = 8'h01;

  logic [1:0] mode;
  logic [1:0] mode_next;
  byte_t      held;
  byte_t      held_next;
  logic       accept;
  logic       do_plain;
  byte_t      hex_byte;
  run_t       run;

  function automatic logic is_hex(input byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Letters have bit 6 set and a low nibble one to six
  function automatic logic [3:0] hex_val(input byte_t c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic run_t run_add(input run_t r, input byte_t b);
    run_t o;
    o = r;
    if (o.cnt != 2'd3) begin
      o.data[o.cnt] = b;
      o.cnt         = o.cnt + 2'd1;
    end
    return o;
  endfunction

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign hex_byte = {hex_val(held), hex_val(s_tdata)};

  always_comb begin
    run       = '0;
    run.eol   = s_tlast;
    mode_next = mode;
    held_next = held;
    do_plain  = 1'b0;
    case (mode)
      MODE_PLAIN: begin
        do_plain = 1'b1;
      end
      MODE_BSL: begin
        mode_next = MODE_PLAIN;
        if (s_tdata == CH_BSL) begin
          run = run_add(run, CH_BSL);
        end else if (s_tdata == CH_LOW_R) begin
          run = run_add(run, CH_CR);
        end else if (s_tdata == CH_LOW_N) begin
          run = run_add(run, CH_LF);
        end else if (s_tdata == CH_LOW_T) begin
          run = run_add(run, CH_TAB);
        end else begin
          run      = run_add(run, CH_BSL);
          do_plain = 1'b1;
        end
      end
      MODE_PCT: begin
        if (is_hex(s_tdata)) begin
          mode_next = MODE_HEX1;
          held_next = s_tdata;
        end else begin
          mode_next = MODE_PLAIN;
          if (s_tdata == CH_PCT) begin
            run = run_add(run, CH_PCT);
          end else if (s_tdata == CH_LOW_T || s_tdata == CH_UP_T) begin
            run = run_add(run, MARK_TAB);
            run = run_add(run, MARK_TAB);
          end else if (s_tdata == CH_LOW_S || s_tdata == CH_UP_S) begin
            run = run_add(run, MARK_SP);
          end else begin
            run      = run_add(run, CH_PCT);
            do_plain = 1'b1;
          end
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
        if (is_hex(s_tdata)) begin
          // drop a decoded zero byte
          if (hex_byte != 8'h00) begin
            run = run_add(run, hex_byte);
          end
        end else begin
          run      = run_add(run, CH_PCT);
          run      = run_add(run, held);
          do_plain = 1'b1;
        end
        held_next = 8'h00;
      end
    endcase

    if (do_plain) begin
      if (s_tdata == CH_BSL) begin
        mode_next = MODE_BSL;
      end else if (s_tdata == CH_PCT) begin
        mode_next = MODE_PCT;
      end else begin
        run = run_add(run, s_tdata);
      end
    end

    // flush whatever escape is still open at line end
    if (s_tlast) begin
      case (mode_next)
        MODE_BSL: begin
          run = run_add(run, CH_BSL);
        end
        MODE_PCT: begin
          run = run_add(run, CH_PCT);
        end
        MODE_HEX1: begin
          run = run_add(run, CH_PCT);
          run = run_add(run, held_next);
        end
        default: begin
        end
      endcase
      mode_next = MODE_PLAIN;
      held_next = 8'h00;
    end
  end

  assign push     = accept && (run.cnt != 2'd0 || s_tlast);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      held <= 8'h00;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

FILE: sv/esld_queue.sv
// ----------------------------------------------------------------------------
// Escape sequence line decoder: run queue
// Short first-in first-out store of run records between front and back.
// ----------------------------------------------------------------------------
module esld_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  esld_pkg::run_t    push_run,
  input  logic              pop,
  output logic              head_valid,
  output esld_pkg::run_t    head_run,
  output esld_pkg::q_stat_t q_stat
);
  import esld_pkg::*;

  run_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_valid   = count != '0;
  assign head_run     = slots[rd_ptr];
  assign q_stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: sv/esld_back.sv
// ----------------------------------------------------------------------------
// Escape sequence line decoder: back end
// Walks the head run one byte a cycle, when the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module esld_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  esld_pkg::run_t head_run,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,   // [7:0] out_byte
  output logic [1:0]     m_tuser,   // [0] byte_valid, [1] last_of_run
  output logic           m_tlast    // line_done
);
  import esld_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       bare;
  logic       last_beat;
  byte_t      beat_byte;

  assign bare      = head_run.cnt == 2'd0;
  assign last_beat = bare || (idx == head_run.cnt - 2'd1);
  assign beat_byte = bare ? 8'h00 : head_run.data[idx];
  assign load      = head_valid && (!m_tvalid || m_tready);
  assign pop       = load && last_beat;

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat_byte;
      m_tuser <= {last_beat, !bare};
      m_tlast <= last_beat && head_run.eol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= last_beat ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/escape_sequence_line_decoder.sv
// Path: an accepted request's run goes into the run queue, then into the output register.
// Throughput: one input byte a cycle while the run queue is not full; a request that
// decodes to k bytes gives k output bytes, and the four-entry run queue absorbs the surplus.
// Reset: synchronous rst clears the escape mode, the held hex digit, the queue pointers
// and count, and the output valid flag and byte index; there is no clearing pass.
// ----------------------------------------------------------------------------
// Escape sequence line decoder
// Backslash and percent-hex unescaper with decoupled classify and emit stages.
// ----------------------------------------------------------------------------
`include "escape_sequence_line_decoder_macros.svh"

module escape_sequence_line_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_line
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] last_of_run
  output logic       m_tlast    // line_done
);
  import esld_pkg::*;

  q_stat_t q_stat;
  logic    push;
  run_t    push_run;
  logic    pop;
  logic    head_valid;
  run_t    head_run;

  esld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  esld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run),
    .q_stat     (q_stat)
  );

  esld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  `ESLD_ASSERT_NOW(a_stall_only_when_full, !s_tready, q_stat.count == QCNT_W'(QUEUE_DEPTH))
  `ESLD_ASSERT_NOW(a_line_done_ends_run, m_tvalid && m_tlast, m_tuser[1])
  `ESLD_ASSERT_NOW(a_bare_marker, m_tvalid && !m_tuser[0], m_tlast && m_tuser[1] && m_tdata == 8'h00)
  `ESLD_ASSERT_NEXT(a_push_seen, push && q_stat.count == '0 && !pop, head_valid)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape sequence line decoder testbench
// Feeds raw text lines, directed escapes first and then random token streams,
// through the slave stream with random gaps while the master side stalls at
// random. A scoreboard decodes every accepted request on its own and compares
// each decoded byte, in order, with what leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import esld_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int CALM_FROM      = 420;
  localparam int DRAIN_CYCLES   = 10;

  localparam byte_t CH_BACKSLASH = 8'h5C;
  localparam byte_t CH_PERCENT   = 8'h25;
  localparam byte_t CH_LO_R      = 8'h72;
  localparam byte_t CH_LO_N      = 8'h6E;
  localparam byte_t CH_LO_T      = 8'h74;
  localparam byte_t CH_UP_T      = 8'h54;
  localparam byte_t CH_LO_S      = 8'h73;
  localparam byte_t CH_UP_S      = 8'h53;
  localparam byte_t CH_DIGIT_0   = 8'h30;
  localparam byte_t CH_DIGIT_9   = 8'h39;
  localparam byte_t CH_UP_A      = 8'h41;
  localparam byte_t CH_UP_F      = 8'h46;
  localparam byte_t CH_LO_A      = 8'h61;
  localparam byte_t CH_LO_F      = 8'h66;
  localparam byte_t CODE_CR      = 8'h0D;
  localparam byte_t CODE_LF      = 8'h0A;
  localparam byte_t CODE_TAB     = 8'h09;
  localparam byte_t MARK_TAB     = 8'h02;
  localparam byte_t MARK_SPACE   = 8'h01;

  localparam string HEX_DIGITS   = "0123456789abcdefABCDEF";
  localparam string BSLASH_TAILS = "\\rnt";
  localparam string PCT_SPECIALS = "%tTsS";

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_AFTER_BACKSLASH,
    MODE_AFTER_PERCENT,
    MODE_AFTER_DIGIT
  } esc_mode_t;

  typedef struct {
    byte_t out_byte;
    bit    byte_valid;
    bit    last_of_run;
    bit    line_done;
  } decoded_t;

  class unescape_tracker;
    esc_mode_t mode;
    byte_t     held_digit;
    byte_t     run_bytes[$];
    decoded_t  decoded_q[$];
    int        failures;

    function new();
      mode       = MODE_PLAIN;
      held_digit = 8'h00;
      failures   = 0;
    endfunction

    function void emit(byte_t b);
      // a run never carries more than RUN_MAX bytes; the surplus is dropped
      if (run_bytes.size() < RUN_MAX) run_bytes.insert(run_bytes.size(), b);
    endfunction

    function bit is_hex(byte_t c);
      return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || (c >= CH_UP_A && c <= CH_UP_F) ||
             (c >= CH_LO_A && c <= CH_LO_F);
    endfunction

    function byte_t hex_value(byte_t c);
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return c - CH_DIGIT_0;
      if (c >= CH_UP_A && c <= CH_UP_F) return c - CH_UP_A + 8'd10;
      if (c >= CH_LO_A && c <= CH_LO_F) return c - CH_LO_A + 8'd10;
      return 8'h00;
    endfunction

    function void take_plain(byte_t c);
      if (c == CH_BACKSLASH) mode = MODE_AFTER_BACKSLASH;
      else if (c == CH_PERCENT) mode = MODE_AFTER_PERCENT;
      else emit(c);
    endfunction

    function void note_request(byte_t c, bit eol);
      byte_t    value;
      decoded_t item;
      run_bytes.delete();
      case (mode)
        MODE_PLAIN: begin
          take_plain(c);
        end
        MODE_AFTER_BACKSLASH: begin
          mode = MODE_PLAIN;
          if (c == CH_BACKSLASH) emit(CH_BACKSLASH);
          else if (c == CH_LO_R) emit(CODE_CR);
          else if (c == CH_LO_N) emit(CODE_LF);
          else if (c == CH_LO_T) emit(CODE_TAB);
          else begin
            emit(CH_BACKSLASH);
            take_plain(c);
          end
        end
        MODE_AFTER_PERCENT: begin
          if (is_hex(c)) begin
            mode       = MODE_AFTER_DIGIT;
            held_digit = c;
          end else begin
            mode = MODE_PLAIN;
            if (c == CH_PERCENT) emit(CH_PERCENT);
            else if (c == CH_LO_T || c == CH_UP_T) begin
              emit(MARK_TAB);
              emit(MARK_TAB);
            end else if (c == CH_LO_S || c == CH_UP_S) emit(MARK_SPACE);
            else begin
              emit(CH_PERCENT);
              take_plain(c);
            end
          end
        end
        default: begin
          mode = MODE_PLAIN;
          if (is_hex(c)) begin
            value = (hex_value(held_digit) << 4) | hex_value(c);
            if (value != 8'h00) emit(value);
          end else begin
            emit(CH_PERCENT);
            emit(held_digit);
            take_plain(c);
          end
          held_digit = 8'h00;
        end
      endcase

      // flush whatever escape is still open at line end
      if (eol) begin
        if (mode == MODE_AFTER_BACKSLASH) emit(CH_BACKSLASH);
        else if (mode == MODE_AFTER_PERCENT) emit(CH_PERCENT);
        else if (mode == MODE_AFTER_DIGIT) begin
          emit(CH_PERCENT);
          emit(held_digit);
        end
        mode       = MODE_PLAIN;
        held_digit = 8'h00;
      end

      if (run_bytes.size() == 0) begin
        if (eol) begin
          item = '{out_byte: 8'h00, byte_valid: 1'b0, last_of_run: 1'b1, line_done: 1'b1};
          decoded_q.insert(decoded_q.size(), item);
        end
      end else begin
        foreach (run_bytes[k]) begin
          item.out_byte    = run_bytes[k];
          item.byte_valid  = 1'b1;
          item.last_of_run = (k == run_bytes.size() - 1);
          item.line_done   = item.last_of_run && eol;
          decoded_q.insert(decoded_q.size(), item);
        end
      end
    endfunction

    function void check_output(byte_t data, bit valid, bit last_run, bit done);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $error("output with nothing pending: out_byte %h byte_valid %b", data, valid);
        failures++;
        return;
      end
      want = decoded_q.pop_front();
      if (data !== want.out_byte) begin
        $error("out_byte mismatch: expected %h, actual %h", want.out_byte, data);
        failures++;
      end
      if (valid !== want.byte_valid) begin
        $error("byte_valid mismatch: expected %b, actual %b", want.byte_valid, valid);
        failures++;
      end
      if (last_run !== want.last_of_run) begin
        $error("last_of_run mismatch: expected %b, actual %b", want.last_of_run, last_run);
        failures++;
      end
      if (done !== want.line_done) begin
        $error("line_done mismatch: expected %b, actual %b", want.line_done, done);
        failures++;
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  byte_t      s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  unescape_tracker tracker;
  int  sent_count;
  int  quiet_cycles;
  bit  src_idle;
  bit  sink_idle;

  escape_sequence_line_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] in_byte
    .s_tlast  (s_tlast),   // end_of_line
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] out_byte
    .m_tuser  (m_tuser),   // [0] byte_valid, [1] last_of_run
    .m_tlast  (m_tlast)    // line_done
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_request(s_tdata, s_tlast);
      if (m_tvalid && m_tready) tracker.check_output(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Sink: stall in random bursts while idling is on
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Entered and left at a falling edge
  task automatic send_request(byte_t c, bit eol);
    if (src_idle && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit eol);
    for (int i = 0; i < s.len(); i++) send_request(s[i], eol && (i == s.len() - 1));
  endtask

  // Hold the stream off until every decoded byte has come out
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  task automatic send_random_token();
    byte_t seq[$];
    int    eol_at;
    case ($urandom_range(0, 9))
      0, 1: seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
      2: begin
        seq.insert(seq.size(), CH_BACKSLASH);
        seq.insert(seq.size(), byte_t'(BSLASH_TAILS[$urandom_range(0, 3)]));
      end
      3: begin
        seq.insert(seq.size(), CH_PERCENT);
        seq.insert(seq.size(), byte_t'(HEX_DIGITS[$urandom_range(0, 21)]));
        seq.insert(seq.size(), byte_t'(HEX_DIGITS[$urandom_range(0, 21)]));
      end
      4: begin
        seq.insert(seq.size(), CH_PERCENT);
        seq.insert(seq.size(), byte_t'(PCT_SPECIALS[$urandom_range(0, 4)]));
      end
      5: begin
        seq.insert(seq.size(), CH_BACKSLASH);
        seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
      end
      6: begin
        seq.insert(seq.size(), CH_PERCENT);
        seq.insert(seq.size(), byte_t'(HEX_DIGITS[$urandom_range(0, 21)]));
        seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
      end
      7: begin
        seq.insert(seq.size(), CH_PERCENT);
        seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
      end
      8: begin
        seq.insert(seq.size(), CH_PERCENT);
        seq.insert(seq.size(), CH_DIGIT_0);
        seq.insert(seq.size(), CH_DIGIT_0);
      end
      default: seq.insert(seq.size(), byte_t'($urandom_range(8'h20, 8'h7E)));
    endcase
    eol_at = -1;
    if ($urandom_range(0, 5) == 0) begin
      // now and then cut the line in the middle of a sequence
      eol_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, seq.size() - 1) : seq.size() - 1;
    end
    foreach (seq[i]) send_request(seq[i], i == eol_at);
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    sent_count   = 0;
    quiet_cycles = 0;
    tracker      = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // known escape, unknown escape opening a hex pair, bad percent, broken hex,
    // then a null pair so the line ends with a bare marker
    send_text("\\r\\%41%z%7!%00", 1'b1);
    // lone hex digit at line end
    send_text("%9", 1'b1);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);
    send_text("%%%t%S", 1'b1);
    // broken hex followed by a backslash flushed at line end fills the run
    send_text("%4\\", 1'b1);

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count % 40 == 0) begin
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      if (sent_count >= CALM_FROM) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      if (sent_count >= RANDOM_ITEMS / 2 && sent_count < RANDOM_ITEMS / 2 + 3) drain_outputs();
      send_random_token();
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
